// ----- rtl/address_stats_aggregator_defines.svh -----
// Assertion macros used by the checker file.
`ifndef ADDRESS_STATS_AGGREGATOR_DEFINES_SVH
`define ADDRESS_STATS_AGGREGATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/asa_pkg.sv -----
package asa_pkg;

    localparam logic [31:0]        GENESIS_RESET = 32'd1231006505;
    localparam logic signed [31:0] NEVER_SEEN    = -32'sd10;
    localparam int                 RESERVED_IDS  = 3;

    typedef enum logic [1:0] {
        OP_SPEND   = 2'd0,
        OP_RECEIVE = 2'd1,
        OP_READ    = 2'd2
    } op_t;

    typedef struct packed {
        logic signed [31:0] first_seen;
        logic signed [31:0] last_seen;
        logic [31:0]        total_count;
        logic [31:0]        spend_count;
        logic [31:0]        receive_count;
        logic signed [63:0] balance;
        logic signed [63:0] peak_balance;
        logic signed [63:0] spent_total;
        logic signed [63:0] received_total;
        logic               multisig;
        logic               seen;
        logic [31:0]        receiver_sum;
        logic [31:0]        spender_sum;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t RESET_ENTRY = '{
        first_seen: NEVER_SEEN,
        last_seen:  NEVER_SEEN,
        default:    '0
    };

endpackage

// ----- rtl/asa_in_if.sv -----
interface asa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] account;
    logic [50:0] amount;
    logic        shared_group;
    logic [31:0] block_time;
    logic [15:0] peer_count;

    modport source (
        output valid, operation, account, amount, shared_group, block_time, peer_count,
        input  ready
    );
    modport sink (
        input  valid, operation, account, amount, shared_group, block_time, peer_count,
        output ready
    );
endinterface

// ----- rtl/asa_out_if.sv -----
interface asa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] first_seen;
    logic signed [31:0] last_seen;
    logic [31:0]        total_count;
    logic [31:0]        spend_count;
    logic [31:0]        receive_count;
    logic signed [63:0] balance;
    logic signed [63:0] peak_balance;
    logic signed [63:0] spent_total;
    logic signed [63:0] received_total;
    logic               multisig;
    logic [31:0]        receiver_sum;
    logic [31:0]        spender_sum;

    modport source (
        output valid, first_seen, last_seen, total_count, spend_count, receive_count,
               balance, peak_balance, spent_total, received_total, multisig,
               receiver_sum, spender_sum,
        input  ready
    );
    modport sink (
        input  valid, first_seen, last_seen, total_count, spend_count, receive_count,
               balance, peak_balance, spent_total, received_total, multisig,
               receiver_sum, spender_sum,
        output ready
    );
endinterface

// ----- rtl/asa_ram.sv -----
module asa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/address_stats_aggregator.sv -----
// Flow: the table entry is read into the RAM output register at the accepting
// edge, then the update is loaded into the result register once that is free.
// One item at a time, set by the read and write-back of one table entry on the
// single RAM; a stalled result holds the update state.
// Reset: asynchronous, active low; genesis_time returns to 1231006505, then a
// clearing pass writes the reset entry to every address, with no item accepted.
module address_stats_aggregator
    import asa_pkg::*;
#(
    parameter int ACCOUNTS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    asa_in_if.sink      occurrence,
    asa_out_if.source   stats
);

    localparam int ADDR_W = $clog2(ACCOUNTS);
    localparam int CMP_W  = ADDR_W + 17;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [31:0]         genesis_reg, genesis_next;
    logic                out_valid_reg, out_valid_next;

    logic [1:0]          op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [50:0]         amount_reg;
    logic                shared_reg;
    logic [31:0]         rel_reg;
    logic [15:0]         peers_reg;
    logic                in_range_reg;
    logic                upd_reg;
    entry_t              res_reg;

    logic                accept;
    logic                load;
    logic [CMP_W-1:0]    acct_ext;
    logic                in_range;
    logic [ADDR_W-1:0]   rd_addr;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    entry_t              cur;
    entry_t              upd;
    logic [63:0]         amt64;

    assign accept   = occurrence.valid && occurrence.ready;
    assign acct_ext = CMP_W'(occurrence.account);
    assign in_range = acct_ext < CMP_W'(ACCOUNTS);
    assign rd_addr  = ADDR_W'(acct_ext);
    assign occurrence.ready = (state_reg == S_IDLE);

    asa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ACCOUNTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Entry update; ids past the table read as the reset entry.
    always_comb
    begin
        amt64 = 64'(amount_reg);
        cur   = in_range_reg ? entry_t'(ram_rdata) : RESET_ENTRY;
        upd   = cur;
        if (upd_reg)
        begin
            case (op_reg)
                OP_SPEND:
                begin
                    upd.spent_total  = cur.spent_total + amt64;
                    upd.balance      = cur.balance - amt64;
                    upd.spend_count  = cur.spend_count + 32'd1;
                    upd.receiver_sum = cur.receiver_sum + 32'(peers_reg);
                end
                OP_RECEIVE:
                begin
                    upd.received_total = cur.received_total + amt64;
                    upd.balance        = cur.balance + amt64;
                    upd.receive_count  = cur.receive_count + 32'd1;
                    upd.spender_sum    = cur.spender_sum + 32'(peers_reg);
                end
                default:
                begin
                end
            endcase
            if ($signed(upd.balance) > $signed(cur.peak_balance))
            begin
                upd.peak_balance = upd.balance;
            end
            upd.multisig = cur.multisig | shared_reg;
            if (!cur.seen)
            begin
                upd.seen       = 1'b1;
                upd.first_seen = rel_reg;
                upd.last_seen  = rel_reg;
            end
            else if ($signed(cur.last_seen) < $signed(rel_reg))
            begin
                upd.last_seen = rel_reg;
            end
            upd.total_count = cur.total_count + 32'd1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        genesis_next   = cfg_wr_en ? cfg_wr_data : genesis_reg;
        out_valid_next = out_valid_reg && !stats.ready;
        load           = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = ENTRY_W'(upd);
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = ENTRY_W'(RESET_ENTRY);
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(ACCOUNTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                // wait until the output register is free
                if (!out_valid_reg || stats.ready)
                begin
                    load           = 1'b1;
                    ram_we         = upd_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            genesis_reg   <= GENESIS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            genesis_reg   <= genesis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= occurrence.operation;
            addr_reg     <= rd_addr;
            amount_reg   <= occurrence.amount;
            shared_reg   <= occurrence.shared_group;
            rel_reg      <= occurrence.block_time - genesis_reg;
            peers_reg    <= occurrence.peer_count;
            in_range_reg <= in_range;
            upd_reg      <= in_range
                            && (occurrence.account >= 16'(RESERVED_IDS))
                            && ((occurrence.operation == OP_SPEND)
                                || (occurrence.operation == OP_RECEIVE));
        end
        if (load)
        begin
            res_reg <= upd;
        end
    end

    assign stats.valid          = out_valid_reg;
    assign stats.first_seen     = res_reg.first_seen;
    assign stats.last_seen      = res_reg.last_seen;
    assign stats.total_count    = res_reg.total_count;
    assign stats.spend_count    = res_reg.spend_count;
    assign stats.receive_count  = res_reg.receive_count;
    assign stats.balance        = res_reg.balance;
    assign stats.peak_balance   = res_reg.peak_balance;
    assign stats.spent_total    = res_reg.spent_total;
    assign stats.received_total = res_reg.received_total;
    assign stats.multisig       = res_reg.multisig;
    assign stats.receiver_sum   = res_reg.receiver_sum;
    assign stats.spender_sum    = res_reg.spender_sum;

endmodule

// ----- rtl/asa_checker.sv -----
`include "address_stats_aggregator_defines.svh"

module asa_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // one item in flight: no accept right after an accept
    `ASA_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "item accepted while another is in flight")

    // a result, new or still stalled, is always waiting once the update state after an accept has passed
    `ASA_ASSERT_IMP(a_result_due, clk, rst_n, in_valid && in_ready, ##2 out_valid, "no result two cycles after accept")

    `ASA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind address_stats_aggregator asa_checker u_asa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (occurrence.valid),
    .in_ready  (occurrence.ready),
    .out_valid (stats.valid),
    .out_ready (stats.ready)
);
